FILE: rtl/eatrm_pkg.sv
// ----------------------------------------------------------------------------
// eatrm_pkg: shared types and constants for the Euler angle rotation core
// Field widths, fixed-point coefficients and angle fold points.
// ----------------------------------------------------------------------------
`default_nettype none

package eatrm_pkg;

  // payload widths
  localparam int ANGLE_W = 16;
  localparam int POS_W   = 32;
  localparam int ENTRY_W = 16;

  typedef logic signed [ANGLE_W-1:0] angle_t;
  typedef logic signed [POS_W-1:0]   pos_t;
  typedef logic        [ENTRY_W-1:0] entry_t;

  // angle units are 1/64 degree, so one turn is 360*64
  localparam logic [14:0] QUARTER = 15'd5760;
  localparam logic [14:0] HALF    = 15'd11520;
  localparam logic [14:0] THREEQ  = 15'd17280;
  localparam logic [14:0] TURN    = 15'd23040;

  // round(pi * 2^30) = PI_Q * HALF + PI_R
  localparam int unsigned PI_Q      = 292817;
  localparam int unsigned PI_R      = 7586;
  // floor(t / 45) = (t * RECIP45) >> RECIP_SH for t below 2^18
  localparam int unsigned RECIP45   = 372828;
  localparam int          RECIP_SH  = 24;

  // cosine polynomial coefficients, Q2.30
  localparam logic signed [31:0] COEF1 = 32'sd1073734624;
  localparam logic signed [31:0] COEF2 = -32'sd536776893;
  localparam logic signed [31:0] COEF3 = 32'sd44547129;
  localparam logic signed [31:0] COEF4 = -32'sd1364951;

  localparam int FBITS = 30;
  localparam logic [30:0] ONE_Q30 = 31'd1073741824;

  // round half up from Q4.60 back to Q2.30
  function automatic logic signed [34:0] rs30(input logic signed [64:0] v);
    logic signed [64:0] w;
    begin
      w = v + 65'sd536870912;
      return 35'(w >>> FBITS);
    end
  endfunction

endpackage

`default_nettype wire

FILE: rtl/eatrm_req_if.sv
// ----------------------------------------------------------------------------
// eatrm_req_if: request channel of the Euler angle rotation core
// Three angles and a position, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface eatrm_req_if;
  logic              valid;
  logic              ready;
  eatrm_pkg::angle_t pitch_deg;
  eatrm_pkg::angle_t yaw_deg;
  eatrm_pkg::angle_t roll_deg;
  eatrm_pkg::pos_t   pos_x;
  eatrm_pkg::pos_t   pos_y;
  eatrm_pkg::pos_t   pos_z;

  modport source (output valid, pitch_deg, yaw_deg, roll_deg, pos_x, pos_y, pos_z,
                  input ready);
  modport sink   (input valid, pitch_deg, yaw_deg, roll_deg, pos_x, pos_y, pos_z,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/eatrm_rsp_if.sv
// ----------------------------------------------------------------------------
// eatrm_rsp_if: response channel of the Euler angle rotation core
// One 3x4 matrix per request, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface eatrm_rsp_if;
  logic              valid;
  logic              ready;
  eatrm_pkg::entry_t r0c0;
  eatrm_pkg::entry_t r0c1;
  eatrm_pkg::entry_t r0c2;
  eatrm_pkg::pos_t   r0c3;
  eatrm_pkg::entry_t r1c0;
  eatrm_pkg::entry_t r1c1;
  eatrm_pkg::entry_t r1c2;
  eatrm_pkg::pos_t   r1c3;
  eatrm_pkg::entry_t r2c0;
  eatrm_pkg::entry_t r2c1;
  eatrm_pkg::entry_t r2c2;
  eatrm_pkg::pos_t   r2c3;

  modport source (output valid, r0c0, r0c1, r0c2, r0c3, r1c0, r1c1, r1c2, r1c3,
                  r2c0, r2c1, r2c2, r2c3, input ready);
  modport sink   (input valid, r0c0, r0c1, r0c2, r0c3, r1c0, r1c1, r1c2, r1c3,
                  r2c0, r2c1, r2c2, r2c3, output ready);
endinterface

`default_nettype wire

FILE: rtl/euler_angles_to_rotation_matrix_core.sv
// ----------------------------------------------------------------------------
// euler_angles_to_rotation_matrix_core: yaw*pitch*roll 3x4 matrix pipeline
// Sine/cosine per angle, then the nine rotation products, position passed on.
// ----------------------------------------------------------------------------
// The core takes one request per clock while it is not stalled and returns one
// matrix per request, in order, through 27 pipeline stages and an output
// register. Most of the stages belong to the sine path: a folded four-term cosine
// polynomial in Horner form (one multiplier per stage) followed by a
// restoring square root that retires up to two result bits per stage over 16
// stages. Backpressure stalls the whole pipeline only when its last stage is
// full and the output register cannot hand its matrix on; bubbles keep
// flowing otherwise. Rotation entries are Q1.(MATRIX_WIDTH-1) rounded half up
// and clamped to [-1, 1 - lsb], presented as their low 16 bits.
`default_nettype none

module euler_angles_to_rotation_matrix_core #(
  parameter int MATRIX_WIDTH = 16
) (
  input  wire logic  clk,
  input  wire logic  rst,
  eatrm_req_if.sink  req,
  eatrm_rsp_if.source rsp
);

  // stage map: 0..7 sine/cosine front end, 8..23 square root, 24..26 matrix
  localparam int SQ_ITERS = 31;
  localparam int SQ_STEPS = 2;
  localparam int NSQ      = (SQ_ITERS + SQ_STEPS - 1) / SQ_STEPS;
  localparam int ST_SQ    = 8;
  localparam int ST_M1    = ST_SQ + NSQ;
  localparam int NST      = ST_M1 + 3;

  // entry rounding, derived from the matrix width
  localparam int FB   = MATRIX_WIDTH - 1;
  localparam int SH   = (FB < eatrm_pkg::FBITS) ? eatrm_pkg::FBITS - FB : 0;
  localparam int SHM1 = (SH > 0) ? SH - 1 : 0;
  localparam int LSH  = (FB > eatrm_pkg::FBITS) ? FB - eatrm_pkg::FBITS : 0;
  localparam logic signed [39:0] ENT_RND = (SH > 0) ? (40'sd1 <<< SHM1) : 40'sd0;
  localparam logic signed [39:0] ENT_HI  = (40'sd1 <<< FB) - 40'sd1;
  localparam logic signed [39:0] ENT_LO  = -(40'sd1 <<< FB);

  function automatic eatrm_pkg::entry_t to_entry(input logic signed [32:0] v);
    logic signed [39:0] r;
    begin
      r = ((40'(v) + ENT_RND) >>> SH) <<< LSH;
      if (r > ENT_HI) r = ENT_HI;
      if (r < ENT_LO) r = ENT_LO;
      return r[15:0];
    end
  endfunction

  // --------------------------------------------------------------------------
  // flow control
  // --------------------------------------------------------------------------
  logic [NST-1:0] v;
  logic           out_take;
  logic           en;

  // output register frees up when empty or being read
  assign out_take  = !rsp.valid || rsp.ready;
  // pipeline moves unless the last stage is stuck behind the output register
  assign en        = !v[NST-1] || out_take;
  assign req.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[NST-2:0], req.valid};
    end
  end

  // position shift line, one entry per stage
  eatrm_pkg::pos_t pos_line [NST][3];

  always_ff @(posedge clk) begin
    if (en) begin
      pos_line[0][0] <= req.pos_x;
      pos_line[0][1] <= req.pos_y;
      pos_line[0][2] <= req.pos_z;
      for (int i = 1; i < NST; i++) begin
        pos_line[i] <= pos_line[i-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // stage 0: magnitude, one-turn reduction, fold into the first quadrant
  // angle index 0 pitch, 1 yaw, 2 roll
  // --------------------------------------------------------------------------
  eatrm_pkg::angle_t ang_in [3];
  assign ang_in[0] = req.pitch_deg;
  assign ang_in[1] = req.yaw_deg;
  assign ang_in[2] = req.roll_deg;

  logic [12:0] s1_f    [3];
  logic        s1_cneg [3];
  logic        s1_sneg [3];

  always_ff @(posedge clk) begin
    logic signed [16:0] vs;
    logic        [16:0] a;
    logic        [14:0] ar;
    logic        [14:0] f;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        vs = 17'(ang_in[i]);
        a  = ang_in[i][15] ? 17'(-vs) : 17'(vs);
        ar = (a >= 17'(eatrm_pkg::TURN)) ? 15'(a - 17'(eatrm_pkg::TURN)) : 15'(a);
        f  = ar;
        if (ar >= eatrm_pkg::QUARTER) f = eatrm_pkg::HALF - ar;
        if (ar >= eatrm_pkg::HALF)    f = ar - eatrm_pkg::HALF;
        if (ar >= eatrm_pkg::THREEQ)  f = eatrm_pkg::TURN - ar;
        s1_f[i]    <= 13'(f);
        s1_cneg[i] <= (ar >= eatrm_pkg::QUARTER) && (ar < eatrm_pkg::THREEQ);
        s1_sneg[i] <= (ar > eatrm_pkg::HALF) ^ ang_in[i][15];
      end
    end
  end

  // --------------------------------------------------------------------------
  // stages 1..2: x = round(f * pi / HALF) in Q2.30, split as f*q + f*r/HALF
  // --------------------------------------------------------------------------
  logic [30:0] s2_fq   [3];
  logic [17:0] s2_t    [3];
  logic        s2_cneg [3];
  logic        s2_sneg [3];

  always_ff @(posedge clk) begin
    logic [26:0] fr;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        fr = 27'(s1_f[i]) * 27'(eatrm_pkg::PI_R) + 27'(eatrm_pkg::HALF >> 1);
        s2_fq[i]   <= 31'(s1_f[i]) * 31'(eatrm_pkg::PI_Q);
        // divide by 256 here, by 45 next stage
        s2_t[i]    <= 18'(fr >> 8);
        s2_cneg[i] <= s1_cneg[i];
        s2_sneg[i] <= s1_sneg[i];
      end
    end
  end

  logic [30:0] s3_x    [3];
  logic        s3_cneg [3];
  logic        s3_sneg [3];

  always_ff @(posedge clk) begin
    logic [36:0] tm;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        tm = 37'(s2_t[i]) * 37'(eatrm_pkg::RECIP45);
        s3_x[i]    <= s2_fq[i] + 31'(tm >> eatrm_pkg::RECIP_SH);
        s3_cneg[i] <= s2_cneg[i];
        s3_sneg[i] <= s2_sneg[i];
      end
    end
  end

  // --------------------------------------------------------------------------
  // stages 3..6: x^2 and the Horner chain of the cosine polynomial
  // --------------------------------------------------------------------------
  logic [31:0] s4_x2   [3];
  logic        s4_cneg [3];
  logic        s4_sneg [3];

  always_ff @(posedge clk) begin
    logic [61:0] xx;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        xx = 62'(s3_x[i]) * 62'(s3_x[i]);
        s4_x2[i]   <= 32'((xx + 62'd536870912) >> eatrm_pkg::FBITS);
        s4_cneg[i] <= s3_cneg[i];
        s4_sneg[i] <= s3_sneg[i];
      end
    end
  end

  logic signed [31:0] s5_p    [3];
  logic        [31:0] s5_x2   [3];
  logic               s5_cneg [3];
  logic               s5_sneg [3];

  always_ff @(posedge clk) begin
    logic signed [64:0] pr;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pr = eatrm_pkg::COEF4 * $signed({1'b0, s4_x2[i]});
        s5_p[i]    <= 32'(35'(eatrm_pkg::COEF3) + eatrm_pkg::rs30(pr));
        s5_x2[i]   <= s4_x2[i];
        s5_cneg[i] <= s4_cneg[i];
        s5_sneg[i] <= s4_sneg[i];
      end
    end
  end

  logic signed [31:0] s6_p    [3];
  logic        [31:0] s6_x2   [3];
  logic               s6_cneg [3];
  logic               s6_sneg [3];

  always_ff @(posedge clk) begin
    logic signed [64:0] pr;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pr = s5_p[i] * $signed({1'b0, s5_x2[i]});
        s6_p[i]    <= 32'(35'(eatrm_pkg::COEF2) + eatrm_pkg::rs30(pr));
        s6_x2[i]   <= s5_x2[i];
        s6_cneg[i] <= s5_cneg[i];
        s6_sneg[i] <= s5_sneg[i];
      end
    end
  end

  logic signed [31:0] s7_p    [3];
  logic               s7_cneg [3];
  logic               s7_sneg [3];

  always_ff @(posedge clk) begin
    logic signed [64:0] pr;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pr = s6_p[i] * $signed({1'b0, s6_x2[i]});
        s7_p[i]    <= 32'(35'(eatrm_pkg::COEF1) + eatrm_pkg::rs30(pr));
        s7_cneg[i] <= s6_cneg[i];
        s7_sneg[i] <= s6_sneg[i];
      end
    end
  end

  // --------------------------------------------------------------------------
  // stage 7: quadrant sign on the cosine, radicand 1 - cos^2 clamped at zero
  // --------------------------------------------------------------------------
  localparam logic signed [31:0] ONE_S = 32'(eatrm_pkg::ONE_Q30);

  logic signed [31:0] s8_cos  [3];
  logic        [30:0] s8_d    [3];
  logic               s8_sneg [3];

  always_ff @(posedge clk) begin
    logic signed [64:0] pr;
    logic signed [34:0] dd;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pr = s7_p[i] * s7_p[i];
        dd = 35'(ONE_S) - eatrm_pkg::rs30(pr);
        s8_cos[i]  <= s7_cneg[i] ? -s7_p[i] : s7_p[i];
        s8_d[i]    <= dd[34] ? 31'd0 : 31'(dd);
        s8_sneg[i] <= s7_sneg[i];
      end
    end
  end

  // --------------------------------------------------------------------------
  // stages 8..23: restoring square root of d * 2^30, up to two result bits a stage
  // --------------------------------------------------------------------------
  logic        [61:0] sq_n    [NSQ+1][3];
  logic        [61:0] sq_r    [NSQ+1][3];
  logic signed [31:0] sq_cos  [NSQ+1][3];
  logic               sq_sneg [NSQ+1][3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sq_n[0][i]    = 62'(s8_d[i]) << eatrm_pkg::FBITS;
      sq_r[0][i]    = '0;
      sq_cos[0][i]  = s8_cos[i];
      sq_sneg[0][i] = s8_sneg[i];
    end
  end

  for (genvar j = 0; j < NSQ; j++) begin : g_sq
    logic [61:0] n_next [3];
    logic [61:0] r_next [3];

    always_comb begin
      logic [61:0] bitv;
      logic [61:0] trial;
      for (int i = 0; i < 3; i++) begin
        n_next[i] = sq_n[j][i];
        r_next[i] = sq_r[j][i];
        for (int k = 0; k < SQ_STEPS; k++) begin
          if (j * SQ_STEPS + k < SQ_ITERS) begin
            bitv  = 62'd1 << (2 * (SQ_ITERS - 1 - (j * SQ_STEPS + k)));
            trial = r_next[i] + bitv;
            if (n_next[i] >= trial) begin
              n_next[i] = n_next[i] - trial;
              r_next[i] = (r_next[i] >> 1) + bitv;
            end else begin
              r_next[i] = r_next[i] >> 1;
            end
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_n[j+1]    <= n_next;
        sq_r[j+1]    <= r_next;
        sq_cos[j+1]  <= sq_cos[j];
        sq_sneg[j+1] <= sq_sneg[j];
      end
    end
  end

  // signed sine and cosine per angle
  logic signed [31:0] sn [3];
  logic signed [31:0] cs [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sn[i] = sq_sneg[NSQ][i] ? -32'(sq_r[NSQ][i][30:0]) : 32'(sq_r[NSQ][i][30:0]);
      cs[i] = sq_cos[NSQ][i];
    end
  end

  // --------------------------------------------------------------------------
  // stage 24: pairwise products of the yaw/roll terms and of cos pitch
  // --------------------------------------------------------------------------
  logic signed [31:0] m1_crcy, m1_crsy, m1_srcy, m1_srsy;
  logic signed [31:0] m1_cpcy, m1_cpsy, m1_srcp, m1_crcp;
  logic signed [31:0] m1_sp;

  function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                             input logic signed [31:0] b);
    logic signed [64:0] pr;
    begin
      pr = a * b;
      return 32'(eatrm_pkg::rs30(pr));
    end
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      m1_crcy <= qmul(cs[2], cs[1]);
      m1_crsy <= qmul(cs[2], sn[1]);
      m1_srcy <= qmul(sn[2], cs[1]);
      m1_srsy <= qmul(sn[2], sn[1]);
      m1_cpcy <= qmul(cs[0], cs[1]);
      m1_cpsy <= qmul(cs[0], sn[1]);
      m1_srcp <= qmul(sn[2], cs[0]);
      m1_crcp <= qmul(cs[2], cs[0]);
      m1_sp   <= sn[0];
    end
  end

  // --------------------------------------------------------------------------
  // stage 25: sin pitch products and the row sums, full Q2.30 precision
  // --------------------------------------------------------------------------
  logic signed [32:0] m2_e [9];

  always_ff @(posedge clk) begin
    if (en) begin
      m2_e[0] <= 33'(m1_cpcy);
      m2_e[1] <= 33'(qmul(m1_sp, m1_srcy)) - 33'(m1_crsy);
      m2_e[2] <= 33'(qmul(m1_sp, m1_crcy)) + 33'(m1_srsy);
      m2_e[3] <= 33'(m1_cpsy);
      m2_e[4] <= 33'(qmul(m1_sp, m1_srsy)) + 33'(m1_crcy);
      m2_e[5] <= 33'(qmul(m1_sp, m1_crsy)) - 33'(m1_srcy);
      m2_e[6] <= -33'(m1_sp);
      m2_e[7] <= 33'(m1_srcp);
      m2_e[8] <= 33'(m1_crcp);
    end
  end

  // --------------------------------------------------------------------------
  // stage 26: round to the entry width and saturate
  // --------------------------------------------------------------------------
  eatrm_pkg::entry_t m3_e [9];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 9; i++) begin
        m3_e[i] <= to_entry(m2_e[i]);
      end
    end
  end

  // --------------------------------------------------------------------------
  // output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (out_take) begin
      rsp.valid <= v[NST-1];
    end
  end

  always_ff @(posedge clk) begin
    if (out_take) begin
      rsp.r0c0 <= m3_e[0];
      rsp.r0c1 <= m3_e[1];
      rsp.r0c2 <= m3_e[2];
      rsp.r0c3 <= pos_line[NST-1][0];
      rsp.r1c0 <= m3_e[3];
      rsp.r1c1 <= m3_e[4];
      rsp.r1c2 <= m3_e[5];
      rsp.r1c3 <= pos_line[NST-1][1];
      rsp.r2c0 <= m3_e[6];
      rsp.r2c1 <= m3_e[7];
      rsp.r2c2 <= m3_e[8];
      rsp.r2c3 <= pos_line[NST-1][2];
    end
  end

`ifndef SYNTH
  // a stall keeps every stage's occupancy
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !en |=> v == $past(v))
    else $error("pipeline occupancy changed during a stall");

  // the pipeline only stalls behind a blocked output register
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !en |-> (v[NST-1] && rsp.valid && !rsp.ready))
    else $error("pipeline stalled without downstream backpressure");

  // folded angle stays within a quarter turn
  a_fold_range: assert property (@(posedge clk) disable iff (rst)
    v[0] |-> (s1_f[0] <= 13'(eatrm_pkg::QUARTER)) && (s1_f[1] <= 13'(eatrm_pkg::QUARTER))
             && (s1_f[2] <= 13'(eatrm_pkg::QUARTER)))
    else $error("folded angle out of first quadrant");

  // radicand never exceeds one
  a_radicand: assert property (@(posedge clk) disable iff (rst)
    v[ST_SQ-1] |-> (s8_d[0] <= eatrm_pkg::ONE_Q30) && (s8_d[1] <= eatrm_pkg::ONE_Q30)
                   && (s8_d[2] <= eatrm_pkg::ONE_Q30))
    else $error("sine radicand above one");
`endif

endmodule

`default_nettype wire

FILE: verif/tb_euler_angles_to_rotation_matrix_core.sv
// ----------------------------------------------------------------------------
// tb_euler_angles_to_rotation_matrix_core: matrix core testbench
// Drives angle/position requests with random idling and backpressure, predicts
// each 3x4 matrix in fixed point and compares every response field.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_euler_angles_to_rotation_matrix_core;

  // pipeline depth from the core header
  localparam int LATENCY = 28;

  typedef struct packed {
    eatrm_pkg::entry_t r0c0, r0c1, r0c2;
    eatrm_pkg::pos_t   r0c3;
    eatrm_pkg::entry_t r1c0, r1c1, r1c2;
    eatrm_pkg::pos_t   r1c3;
    eatrm_pkg::entry_t r2c0, r2c1, r2c2;
    eatrm_pkg::pos_t   r2c3;
  } matrix_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   errors = 0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  bit   recv_hold = 1'b0;
  int   hold_cycles = 0;
  int   hold_len = 0;
  bit   hold_tog = 1'b0;
  bit   hold_seen = 1'b0;
  matrix_t matrix_q[$];

  eatrm_req_if req ();
  eatrm_rsp_if rsp ();

  euler_angles_to_rotation_matrix_core u_dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // fixed-point predictor
  // ---------------------------------------------------------------------------

  // round half up by 2^s, signed
  function automatic longint rnd_shift(input longint v, input int s);
    longint w;
    w = v + (longint'(1) << (s - 1));
    return w >>> s;
  endfunction

  function automatic longint qmul30(input longint a, input longint b);
    return rnd_shift(a * b, 30);
  endfunction

  function automatic longint floor_sqrt(input longint unsigned n);
    longint unsigned res, bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n   = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return longint'(res);
  endfunction

  // sine and cosine of an angle in 1/64 degree, both Q2.30
  function automatic void angle_sin_cos(input eatrm_pkg::angle_t ang, output longint s,
                                        output longint c);
    longint a, f, x, x2, p, d;
    a = (ang < 0) ? -longint'(ang) : longint'(ang);
    if (a >= 23040) a -= 23040;
    f = a;
    if (a >= 5760) f = 11520 - a;
    if (a >= 11520) f = a - 11520;
    if (a >= 17280) f = 23040 - a;
    x  = (f * 64'sd3373259426 + 5760) / 11520;
    x2 = qmul30(x, x);
    p  = longint'(eatrm_pkg::COEF3) + qmul30(longint'(eatrm_pkg::COEF4), x2);
    p  = longint'(eatrm_pkg::COEF2) + qmul30(p, x2);
    p  = longint'(eatrm_pkg::COEF1) + qmul30(p, x2);
    c  = (a >= 5760 && a < 17280) ? -p : p;
    d  = (longint'(1) << 30) - qmul30(c, c);
    if (d < 0) d = 0;
    s = floor_sqrt(longint'(d) << 30);
    if (a > 11520) s = -s;
    if (ang < 0) s = -s;
  endfunction

  // Q2.30 to Q1.15 with saturation at 1 - lsb and -1
  function automatic eatrm_pkg::entry_t q30_to_entry(input longint v);
    longint r;
    r = rnd_shift(v, 15);
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return eatrm_pkg::entry_t'(r);
  endfunction

  function automatic matrix_t predict_matrix(input eatrm_pkg::angle_t pitch,
                                             input eatrm_pkg::angle_t yaw,
                                             input eatrm_pkg::angle_t roll,
                                             input eatrm_pkg::pos_t px,
                                             input eatrm_pkg::pos_t py,
                                             input eatrm_pkg::pos_t pz);
    longint sp, cp, sy, cy, sr, cr, crcy, crsy, srcy, srsy;
    matrix_t m;
    angle_sin_cos(pitch, sp, cp);
    angle_sin_cos(yaw, sy, cy);
    angle_sin_cos(roll, sr, cr);
    crcy = qmul30(cr, cy);
    crsy = qmul30(cr, sy);
    srcy = qmul30(sr, cy);
    srsy = qmul30(sr, sy);
    m.r0c0 = q30_to_entry(qmul30(cp, cy));
    m.r0c1 = q30_to_entry(qmul30(sp, srcy) - crsy);
    m.r0c2 = q30_to_entry(qmul30(sp, crcy) + srsy);
    m.r0c3 = px;
    m.r1c0 = q30_to_entry(qmul30(cp, sy));
    m.r1c1 = q30_to_entry(qmul30(sp, srsy) + crcy);
    m.r1c2 = q30_to_entry(qmul30(sp, crsy) - srcy);
    m.r1c3 = py;
    m.r2c0 = q30_to_entry(-sp);
    m.r2c1 = q30_to_entry(qmul30(sr, cp));
    m.r2c2 = q30_to_entry(qmul30(cr, cp));
    m.r2c3 = pz;
    return m;
  endfunction

  // ---------------------------------------------------------------------------
  // request driver
  // ---------------------------------------------------------------------------

  // send one request; random idle cycles ahead of it, then hold until accepted
  // valid stays high afterwards so the next request can follow back to back
  task automatic send_request(input eatrm_pkg::angle_t pitch, input eatrm_pkg::angle_t yaw,
                              input eatrm_pkg::angle_t roll, input eatrm_pkg::pos_t px,
                              input eatrm_pkg::pos_t py, input eatrm_pkg::pos_t pz);
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid     <= 1'b1;
    req.pitch_deg <= pitch;
    req.yaw_deg   <= yaw;
    req.roll_deg  <= roll;
    req.pos_x     <= px;
    req.pos_y     <= py;
    req.pos_z     <= pz;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    // accepted at this edge: record the expected matrix
    matrix_q.push_back(predict_matrix(pitch, yaw, roll, px, py, pz));
  endtask

  function automatic eatrm_pkg::angle_t rand_angle();
    case ($urandom_range(3))
      0: return eatrm_pkg::angle_t'($urandom);
      // near the fold points, including either sign and over one turn
      1: return eatrm_pkg::angle_t'((int'($urandom_range(4)) * 5760
                                     + int'($urandom_range(8)) - 4)
                                    * ($urandom_range(1) ? 1 : -1));
      2: return eatrm_pkg::angle_t'($urandom_range(1) ? 16'sh7fff - $urandom_range(20)
                                                      : 16'sh8000 + $urandom_range(20));
      default: return eatrm_pkg::angle_t'($urandom_range(23040)
                                          * ($urandom_range(1) ? 1 : -1));
    endcase
  endfunction

  task automatic send_random(input int n);
    for (int i = 0; i < n; i++)
      send_request(rand_angle(), rand_angle(), rand_angle(), $urandom, $urandom, $urandom);
  endtask

  task automatic wait_drained();
    req.valid <= 1'b0;
    while (matrix_q.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // response checker and receiver stalls
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else if (recv_hold) begin
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // long receiver hold-off, counted here in cycles
  always @(posedge clk) begin
    if (hold_tog != hold_seen) begin
      hold_seen   <= hold_tog;
      hold_cycles <= hold_len;
    end else if (hold_cycles > 0) begin
      recv_hold   <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      recv_hold <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready) begin
      matrix_t got, want;
      got = {rsp.r0c0, rsp.r0c1, rsp.r0c2, rsp.r0c3, rsp.r1c0, rsp.r1c1, rsp.r1c2,
             rsp.r1c3, rsp.r2c0, rsp.r2c1, rsp.r2c2, rsp.r2c3};
      if (matrix_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected matrix, actual %h", $time, got);
      end else begin
        want = matrix_q.pop_front();
        if (got.r0c0 != want.r0c0) begin
          errors++;
          $display("%0t: r0c0 expected %h actual %h", $time, want.r0c0, got.r0c0);
        end
        if (got.r0c1 != want.r0c1) begin
          errors++;
          $display("%0t: r0c1 expected %h actual %h", $time, want.r0c1, got.r0c1);
        end
        if (got.r0c2 != want.r0c2) begin
          errors++;
          $display("%0t: r0c2 expected %h actual %h", $time, want.r0c2, got.r0c2);
        end
        if (got.r0c3 != want.r0c3) begin
          errors++;
          $display("%0t: r0c3 expected %h actual %h", $time, want.r0c3, got.r0c3);
        end
        if (got.r1c0 != want.r1c0) begin
          errors++;
          $display("%0t: r1c0 expected %h actual %h", $time, want.r1c0, got.r1c0);
        end
        if (got.r1c1 != want.r1c1) begin
          errors++;
          $display("%0t: r1c1 expected %h actual %h", $time, want.r1c1, got.r1c1);
        end
        if (got.r1c2 != want.r1c2) begin
          errors++;
          $display("%0t: r1c2 expected %h actual %h", $time, want.r1c2, got.r1c2);
        end
        if (got.r1c3 != want.r1c3) begin
          errors++;
          $display("%0t: r1c3 expected %h actual %h", $time, want.r1c3, got.r1c3);
        end
        if (got.r2c0 != want.r2c0) begin
          errors++;
          $display("%0t: r2c0 expected %h actual %h", $time, want.r2c0, got.r2c0);
        end
        if (got.r2c1 != want.r2c1) begin
          errors++;
          $display("%0t: r2c1 expected %h actual %h", $time, want.r2c1, got.r2c1);
        end
        if (got.r2c2 != want.r2c2) begin
          errors++;
          $display("%0t: r2c2 expected %h actual %h", $time, want.r2c2, got.r2c2);
        end
        if (got.r2c3 != want.r2c3) begin
          errors++;
          $display("%0t: r2c3 expected %h actual %h", $time, want.r2c3, got.r2c3);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // extremes, fold points, half turn, saturation at +1, position extremes
  task automatic test_directed();
    eatrm_pkg::angle_t angs[13] = '{16'sd0, 16'sd5760, 16'sd11520, 16'sd17280, 16'sd23040,
                                    -16'sd5760, -16'sd11520, 16'sd11519, 16'sd11521,
                                    16'sh7fff, 16'sh8000, 16'sd1, -16'sd1};
    foreach (angs[i])
      send_request(angs[i], angs[(i + 4) % 13], angs[(i + 7) % 13],
                   32'h7fffffff, 32'h80000000, i[0] ? 32'hffffffff : 32'h0);
    // every bit of every field both ways
    send_request(16'shffff, 16'shffff, 16'shffff, '1, '1, '1);
    send_request(16'sh5555, 16'shaaaa, 16'sh5555, 32'h55555555, 32'haaaaaaaa, 32'h55555555);
    send_request(16'shaaaa, 16'sh5555, 16'shaaaa, 32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa);
  endtask

  // sender pauses until every matrix has come back
  task automatic test_drain_pause();
    send_random(20);
    wait_drained();
    send_random(20);
  endtask

  // receiver holds off long enough for the pipeline to fill and stall requests
  task automatic test_backpressure();
    hold_len = 4 * LATENCY;
    hold_tog = ~hold_tog;
    send_random(100);
  endtask

  task automatic test_random_idling();
    send_idle_pct = 23; recv_idle_pct = 57;
    send_random(350);
    send_idle_pct = 57; recv_idle_pct = 23;
    send_random(350);
    send_idle_pct = 0;  recv_idle_pct = 0;
    send_random(350);
  endtask

  initial begin
    req.valid     = 1'b0;
    req.pitch_deg = '0;
    req.yaw_deg   = '0;
    req.roll_deg  = '0;
    req.pos_x     = '0;
    req.pos_y     = '0;
    req.pos_z     = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_drain_pause();
    test_backpressure();
    test_random_idling();
    wait_drained();
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  // generous run limit
  initial begin
    #400000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

`default_nettype wire
